### hw/rtl/mbrtu_pkg.sv
// Shared types, constants and CRC table function for the Modbus RTU response receiver.
package mbrtu_pkg;

  localparam int unsigned MaxFrameBytesDef = 256;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned GapW     = 16;
  localparam int unsigned SilenceW = 16;
  localparam int unsigned TimerW   = 20;
  localparam int unsigned CfgW     = 20;
  localparam int unsigned CfgIdxW  = 2;

  // Defaults at 9600 baud: t1.5 and t3.5 in microseconds, 100 ms response timeout.
  localparam logic [GapW-1:0]     GapEndReset  = GapW'(15000000 / 9600);
  localparam logic [SilenceW-1:0] SilenceReset = SilenceW'(35000000 / 9600);
  localparam logic [TimerW-1:0]   TimeoutReset = TimerW'(100 * 1000);

  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};
  localparam logic [15:0]       CrcInit  = 16'hFFFF;
  localparam logic [15:0]       CrcPoly  = 16'hA001;

  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpByte  = 2'd1,
    OpTick  = 2'd2,
    OpNop   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StTimeout  = 2'd1,
    StCrcError = 2'd2,
    StTooShort = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhWait    = 2'd1,
    PhCollect = 2'd2,
    PhSilence = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGapEnd  = 2'd0,
    CfgSilence = 2'd1,
    CfgTimeout = 2'd2
  } cfg_idx_e;

  localparam logic KindEcho    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [ByteW-1:0] rx_byte;
  } mbrtu_in_t;

  typedef struct packed {
    logic             result_kind;
    logic [ByteW-1:0] byte_value;
    logic [ByteW-1:0] byte_index;
    logic [1:0]       status;
    logic [ByteW-1:0] slave_address;
    logic [ByteW-1:0] function_code;
    logic             is_exception;
    logic [ByteW-1:0] exception_code;
    logic [ByteW-1:0] pdu_length;
  } mbrtu_out_t;

  typedef struct packed {
    logic [GapW-1:0]     gap_end_ticks;
    logic [SilenceW-1:0] silence_ticks;
    logic [TimerW-1:0]   response_timeout_ticks;
  } mbrtu_cfg_t;

  // One entry of the reflected CRC-16/MODBUS byte table.
  function automatic logic [15:0] crc_table(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Table-driven update of the running CRC with one byte.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    return {8'h00, crc[15:8]} ^ crc_table(crc[7:0] ^ b);
  endfunction

endpackage

### hw/rtl/modbus_rtu_response_receiver.sv
// Top level of the Modbus RTU response receiver: input register, frame logic, result register.
//
// Takes one item per clock while in_stall_o is low: a start command, a received UART byte or a
// one-microsecond tick. Every item passes an input register, the frame logic (state machine,
// saturating 20-bit tick timer, header capture and a single table step of CRC-16/MODBUS)
// and lands in a result register, from which its result is offered, and the block sustains
// one item per cycle for as long as the result side does
// not stall. A stall on the result side holds the result register and, once the input
// register is also full, raises in_stall_o. Each accepted byte in a frame is echoed with
// its index; a frame ends on more than gap_end_ticks of silence or at MaxFrameBytes
// bytes, and after silence_ticks of silence a verdict reports status, header and payload
// length. Bytes arriving while idle or during silence are dropped. Configuration writes
// take effect at once and are meant to happen only while the block is idle.
module modbus_rtu_response_receiver #(
  parameter int unsigned MaxFrameBytes = mbrtu_pkg::MaxFrameBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbrtu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mbrtu_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mbrtu_pkg::mbrtu_in_t          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mbrtu_pkg::mbrtu_out_t         out_data_o
);

  mbrtu_pkg::mbrtu_cfg_t cfg;
  mbrtu_pkg::mbrtu_in_t  in_q;
  mbrtu_pkg::mbrtu_out_t out_q;
  mbrtu_pkg::mbrtu_out_t res;
  logic                  in_valid_q;
  logic                  out_valid_q;
  logic                  res_valid;
  logic                  out_free;
  logic                  advance;
  logic                  in_accept;

  // Result register is free when empty or being taken this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  // Process the held item only when its result has somewhere to go.
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  mbrtu_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mbrtu_frame_ctrl #(
    .MaxFrameBytes (MaxFrameBytes)
  ) u_frame_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register: load on accept, drop once processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // Result register: refill or empty whenever it is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with no item held");

  a_timeout_fields_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == mbrtu_pkg::KindVerdict &&
    out_data_o.status == mbrtu_pkg::StTimeout
    |-> out_data_o.slave_address == 8'h00 && out_data_o.pdu_length == 8'h00)
    else $error("timeout verdict carries frame fields");

  a_echo_fields_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == mbrtu_pkg::KindEcho
    |-> out_data_o.status == mbrtu_pkg::StOk && out_data_o.pdu_length == 8'h00)
    else $error("echo item carries verdict fields");

  a_held_result_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result lost or changed");

endmodule

### hw/rtl/mbrtu_cfg_regs.sv
// Configuration registers of the Modbus RTU response receiver.
module mbrtu_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mbrtu_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mbrtu_pkg::CfgW-1:0]          cfg_wdata_i,
  output mbrtu_pkg::mbrtu_cfg_t               cfg_o
);

  mbrtu_pkg::mbrtu_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (mbrtu_pkg::cfg_idx_e'(cfg_idx_i))
        mbrtu_pkg::CfgGapEnd:  cfg_d.gap_end_ticks = cfg_wdata_i[mbrtu_pkg::GapW-1:0];
        mbrtu_pkg::CfgSilence: cfg_d.silence_ticks = cfg_wdata_i[mbrtu_pkg::SilenceW-1:0];
        mbrtu_pkg::CfgTimeout: begin
          cfg_d.response_timeout_ticks = cfg_wdata_i[mbrtu_pkg::TimerW-1:0];
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_end_ticks          <= mbrtu_pkg::GapEndReset;
      cfg_q.silence_ticks          <= mbrtu_pkg::SilenceReset;
      cfg_q.response_timeout_ticks <= mbrtu_pkg::TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/mbrtu_frame_ctrl.sv
// Frame state machine, timers, header capture and CRC check of the receiver.
module mbrtu_frame_ctrl #(
  parameter int unsigned MaxFrameBytes = mbrtu_pkg::MaxFrameBytesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  mbrtu_pkg::mbrtu_in_t   item_i,
  input  mbrtu_pkg::mbrtu_cfg_t  cfg_i,
  output logic                   res_valid_o,
  output mbrtu_pkg::mbrtu_out_t  res_o
);

  localparam int unsigned CntW = $clog2(MaxFrameBytes + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxFrameBytes);
  localparam logic [CntW-1:0] MinCnt = CntW'(3);
  localparam logic [CntW-1:0] CrcStartCnt = CntW'(2);

  mbrtu_pkg::phase_e phase_q, phase_d;
  logic [mbrtu_pkg::TimerW-1:0] timer_q, timer_d, timer_inc;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [15:0]      crc_q, crc_d;
  logic [15:0]      tail_q, tail_d;
  logic [7:0]       addr_q, addr_d;
  logic [7:0]       func_q, func_d;
  logic [7:0]       third_q, third_d;

  logic                        do_verdict;
  logic                        check_silence;
  mbrtu_pkg::status_e          vstatus;
  mbrtu_pkg::status_e          frame_status;
  logic                        crc_match;

  assign timer_inc = (timer_q == mbrtu_pkg::TimerMax) ? timer_q
                                                      : timer_q + mbrtu_pkg::TimerW'(1);
  assign cnt_inc   = cnt_q + CntW'(1);

  // The CRC trails the input by two bytes; the tail holds the received CRC, low byte first.
  assign crc_match    = (tail_q[15:8] == crc_q[7:0]) && (tail_q[7:0] == crc_q[15:8]);
  assign frame_status = (cnt_q < MinCnt) ? mbrtu_pkg::StTooShort :
                        crc_match        ? mbrtu_pkg::StOk : mbrtu_pkg::StCrcError;

  always_comb begin
    phase_d       = phase_q;
    timer_d       = timer_q;
    cnt_d         = cnt_q;
    crc_d         = crc_q;
    tail_d        = tail_q;
    addr_d        = addr_q;
    func_d        = func_q;
    third_d       = third_q;
    res_valid_o   = 1'b0;
    res_o         = '0;
    do_verdict    = 1'b0;
    check_silence = 1'b0;
    vstatus       = mbrtu_pkg::StOk;

    if (step_i) begin
      case (mbrtu_pkg::op_e'(item_i.opcode))
        mbrtu_pkg::OpStart: begin
          // Abandon any frame in progress and rearm.
          phase_d = mbrtu_pkg::PhWait;
          timer_d = '0;
          cnt_d   = '0;
          crc_d   = mbrtu_pkg::CrcInit;
          tail_d  = '0;
          addr_d  = '0;
          func_d  = '0;
          third_d = '0;
        end
        mbrtu_pkg::OpByte: begin
          if (phase_q inside {mbrtu_pkg::PhWait, mbrtu_pkg::PhCollect}) begin
            if (cnt_q >= CrcStartCnt) begin
              crc_d = mbrtu_pkg::crc_feed(crc_q, tail_q[15:8]);
            end
            tail_d = {tail_q[7:0], item_i.rx_byte};
            if (cnt_q == CntW'(0)) begin
              addr_d = item_i.rx_byte;
            end
            if (cnt_q == CntW'(1)) begin
              func_d = item_i.rx_byte;
            end
            if (cnt_q == CntW'(2)) begin
              third_d = item_i.rx_byte;
            end
            cnt_d   = cnt_inc;
            timer_d = '0;
            phase_d = (cnt_inc >= MaxCnt) ? mbrtu_pkg::PhSilence : mbrtu_pkg::PhCollect;
            res_valid_o      = 1'b1;
            res_o.result_kind = mbrtu_pkg::KindEcho;
            res_o.byte_value  = item_i.rx_byte;
            res_o.byte_index  = 8'(cnt_q);
          end
        end
        mbrtu_pkg::OpTick: begin
          if (phase_q != mbrtu_pkg::PhIdle) begin
            timer_d = timer_inc;
            case (phase_q)
              mbrtu_pkg::PhWait: begin
                if (timer_inc >= cfg_i.response_timeout_ticks) begin
                  do_verdict = 1'b1;
                  vstatus    = mbrtu_pkg::StTimeout;
                end
              end
              mbrtu_pkg::PhCollect: begin
                if (timer_inc > {4'h0, cfg_i.gap_end_ticks}) begin
                  phase_d       = mbrtu_pkg::PhSilence;
                  check_silence = 1'b1;
                end
              end
              mbrtu_pkg::PhSilence: check_silence = 1'b1;
              default: check_silence = 1'b0;
            endcase
            if (check_silence && (timer_inc >= {4'h0, cfg_i.silence_ticks})) begin
              do_verdict = 1'b1;
              vstatus    = frame_status;
            end
          end
        end
        default: phase_d = phase_q;
      endcase

      if (do_verdict) begin
        phase_d           = mbrtu_pkg::PhIdle;
        res_valid_o       = 1'b1;
        res_o.result_kind = mbrtu_pkg::KindVerdict;
        res_o.status      = vstatus;
        if (vstatus != mbrtu_pkg::StTimeout) begin
          res_o.slave_address  = addr_q;
          res_o.function_code  = func_q;
          res_o.is_exception   = func_q[7];
          res_o.exception_code = func_q[7] ? third_q : 8'h00;
          res_o.pdu_length     = (cnt_q >= MinCnt) ? 8'(cnt_q - MinCnt) : 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mbrtu_pkg::PhIdle;
      timer_q <= '0;
      cnt_q   <= '0;
      crc_q   <= mbrtu_pkg::CrcInit;
      tail_q  <= '0;
      addr_q  <= '0;
      func_q  <= '0;
      third_q <= '0;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      tail_q  <= tail_d;
      addr_q  <= addr_d;
      func_q  <= func_d;
      third_q <= third_d;
    end
  end

  a_cnt_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("byte count beyond frame limit");

  a_collect_has_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mbrtu_pkg::PhCollect |-> cnt_q != '0)
    else $error("collecting with no byte received");

endmodule
